FILE: sv/line_pixel_generator_macros.svh
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared concurrent assertion forms for the checker of the line pixel generator.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_MACROS_SVH
`define LINE_PIXEL_GENERATOR_MACROS_SVH

// Implication checked at every rising edge, switched off while reset is high.
`define LPG_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line pixel generator check failed");

// Implication checked at every rising edge, reset included.
`define LPG_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("line pixel generator check failed");

`endif

FILE: sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel generator package
// Shared constants, action codes and the step direction record.
// ----------------------------------------------------------------------------
package lpg_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_STEP = 1'b1
   } lpg_action_type;

   // Step directions of a line, worked out when it is loaded.
   typedef struct packed {
      logic y_neg;
      logic y_move;
      logic x_neg;
      logic x_move;
   } lpg_signs_type;

   localparam int SIGNS_BITS = $bits(lpg_signs_type);

   // Width of one classified transaction held between front and back:
   // action, four coordinates, two magnitudes and the direction record.
   function automatic int lpg_item_bits(input int coord_bits);
      return 1 + 4 * coord_bits + 2 * (coord_bits + 1) + SIGNS_BITS;
   endfunction

endpackage

FILE: sv/lpg_front.sv
// ----------------------------------------------------------------------------
// Line pixel generator front end
// Accepts request transactions, works out deltas and directions of a load.
// ----------------------------------------------------------------------------
module lpg_front #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic                                          req_action,
   input  logic signed [COORD_BITS-1:0]                  req_start_x,
   input  logic signed [COORD_BITS-1:0]                  req_start_y,
   input  logic signed [COORD_BITS-1:0]                  req_end_x,
   input  logic signed [COORD_BITS-1:0]                  req_end_y,
   output logic                                          item_valid,
   output logic [lpg_pkg::lpg_item_bits(COORD_BITS)-1:0] item_data,
   input  logic                                          item_ready
);
   import lpg_pkg::*;

   localparam int ITEM_BITS = lpg_item_bits(COORD_BITS);

   logic                  front_valid_ff;
   logic                  front_valid_in;
   logic [ITEM_BITS-1:0]  front_data_ff;
   logic [ITEM_BITS-1:0]  front_data_in;
   logic                  accept;
   logic [COORD_BITS:0]   dx_diff;
   logic [COORD_BITS:0]   dy_diff;
   logic [COORD_BITS:0]   dx_abs;
   logic [COORD_BITS:0]   dy_abs;
   lpg_signs_type         signs;

   assign req_stall = front_valid_ff && !item_ready;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      dx_diff = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
      dy_diff = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
      dx_abs  = dx_diff[COORD_BITS] ? (~dx_diff + 1'b1) : dx_diff;
      dy_abs  = dy_diff[COORD_BITS] ? (~dy_diff + 1'b1) : dy_diff;
      signs.x_move = |dx_diff;
      signs.x_neg  = dx_diff[COORD_BITS];
      signs.y_move = |dy_diff;
      signs.y_neg  = dy_diff[COORD_BITS];
      front_data_in = {req_action, req_start_x, req_start_y, req_end_x, req_end_y,
                       dx_abs, dy_abs, signs};
   end

   assign front_valid_in = accept || (front_valid_ff && !item_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_data_ff <= front_data_in;
      end
   end

   assign item_valid = front_valid_ff;
   assign item_data  = front_data_ff;

endmodule

FILE: sv/lpg_queue.sv
// ----------------------------------------------------------------------------
// Line pixel generator queue
// Short first-in first-out buffer between the front end and the engine.
// ----------------------------------------------------------------------------
module lpg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lpg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   input  logic             out_pop
);
   import lpg_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      store_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = (count_ff != COUNT_BITS'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

FILE: sv/lpg_back.sv
// ----------------------------------------------------------------------------
// Line pixel generator engine
// Holds the line state, runs one error-term step per step transaction on an active line.
// ----------------------------------------------------------------------------
module lpg_back #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          item_valid,
   input  logic [lpg_pkg::lpg_item_bits(COORD_BITS)-1:0] item_data,
   output logic                                          item_pop,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic signed [COORD_BITS-1:0]                  rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]                  rsp_pixel_y,
   output logic                                          rsp_last
);
   import lpg_pkg::*;

   localparam int C = COORD_BITS;

   logic                 it_action;
   logic [C-1:0]         it_sx;
   logic [C-1:0]         it_sy;
   logic [C-1:0]         it_ex;
   logic [C-1:0]         it_ey;
   logic [C:0]           it_dx;
   logic [C:0]           it_dy;
   lpg_signs_type        it_signs;

   logic [C-1:0]         cur_x_ff, cur_x_in;
   logic [C-1:0]         cur_y_ff, cur_y_in;
   logic [C-1:0]         goal_x_ff, goal_x_in;
   logic [C-1:0]         goal_y_ff, goal_y_in;
   logic [C:0]           delta_x_ff, delta_x_in;
   logic [C:0]           delta_y_ff, delta_y_in;
   lpg_signs_type        signs_ff, signs_in;
   logic [C+1:0]         err_ff, err_in;
   logic                 active_ff, active_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]         rsp_x_ff, rsp_x_in;
   logic [C-1:0]         rsp_y_ff, rsp_y_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 is_load;
   logic                 out_free;
   logic                 emit;
   logic signed [C+2:0]  err_ext;
   logic signed [C+2:0]  dx_ext;
   logic signed [C+2:0]  dy_ext;
   logic signed [C+2:0]  err_sum;
   logic                 cond_x;
   logic                 cond_y;
   logic [C-1:0]         x_step;
   logic [C-1:0]         y_step;
   logic [C-1:0]         x_next;
   logic [C-1:0]         y_next;
   logic                 at_goal;
   logic [C+1:0]         half_dx;
   logic [C+1:0]         half_dy;
   logic [C+1:0]         err_load;

   assign {it_action, it_sx, it_sy, it_ex, it_ey, it_dx, it_dy, it_signs} = item_data;

   assign is_load  = (lpg_action_type'(it_action) == ACT_LOAD);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign item_pop = item_valid && (is_load || !active_ff || out_free);
   assign emit     = item_pop && !is_load && active_ff;

   // One error-term step from the registered line state.
   always_comb begin
      err_ext = {err_ff[C+1], err_ff};
      dx_ext  = {2'b00, delta_x_ff};
      dy_ext  = {2'b00, delta_y_ff};
      cond_x  = err_ext > -dx_ext;
      cond_y  = err_ext < dy_ext;
      err_sum = err_ext - (cond_x ? dy_ext : '0) + (cond_y ? dx_ext : '0);
      x_step  = (cond_x && signs_ff.x_move) ? (signs_ff.x_neg ? {C{1'b1}} : C'(1)) : '0;
      y_step  = (cond_y && signs_ff.y_move) ? (signs_ff.y_neg ? {C{1'b1}} : C'(1)) : '0;
      x_next  = cur_x_ff + x_step;
      y_next  = cur_y_ff + y_step;
      at_goal = (x_next == goal_x_ff) && (y_next == goal_y_ff);
   end

   // Starting error term: half the larger delta, negated unless dx is strictly larger.
   always_comb begin
      half_dx  = {2'b00, it_dx[C:1]};
      half_dy  = {2'b00, it_dy[C:1]};
      err_load = (it_dx > it_dy) ? half_dx : (~half_dy + 1'b1);
   end

   always_comb begin
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      goal_x_in  = goal_x_ff;
      goal_y_in  = goal_y_ff;
      delta_x_in = delta_x_ff;
      delta_y_in = delta_y_ff;
      signs_in   = signs_ff;
      err_in     = err_ff;
      active_in  = active_ff;
      if (item_pop && is_load) begin
         cur_x_in   = it_sx;
         cur_y_in   = it_sy;
         goal_x_in  = it_ex;
         goal_y_in  = it_ey;
         delta_x_in = it_dx;
         delta_y_in = it_dy;
         signs_in   = it_signs;
         err_in     = err_load;
         active_in  = (it_sx != it_ex) || (it_sy != it_ey);
      end else if (emit) begin
         cur_x_in  = x_next;
         cur_y_in  = y_next;
         err_in    = err_sum[C+1:0];
         active_in = !at_goal;
      end
   end

   always_comb begin
      rsp_x_in    = rsp_x_ff;
      rsp_y_in    = rsp_y_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = cur_x_ff;
         rsp_y_in     = cur_y_ff;
         rsp_last_in  = at_goal;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      goal_x_ff   <= goal_x_in;
      goal_y_ff   <= goal_y_in;
      delta_x_ff  <= delta_x_in;
      delta_y_ff  <= delta_y_in;
      signs_ff    <= signs_in;
      err_ff      <= err_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pixel_x = rsp_x_ff;
   assign rsp_pixel_y = rsp_y_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

FILE: sv/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// Line pixel generator
// All-octant integer Bresenham rasteriser, one pixel per step transaction.
// ----------------------------------------------------------------------------
// Usage. The request channel (req_) carries two kinds of transaction. A load
// (req_action low) gives the start and end points of a line and produces no
// response. A step (req_action high) produces one response on the rsp_
// channel carrying the current pixel, then advances the position; rsp_last
// marks the pixel after which the end point is reached. The end point itself
// is never sent, and a line whose end points coincide gives no pixels. A step
// with no line loaded, or after the last pixel, is absorbed without response.
// An accepted step reaches its response through the front register, the
// queue and the response register. Throughput is one transaction per cycle
// while no stall holds it; the engine's error-term update is combinational.
// The front classifies and computes deltas, a two-entry queue decouples it
// from the engine. When the receiver stalls, the response holds, the queue
// fills and req_stall rises only once the queue and front register are full.
// Synchronous reset empties the front and queue, drops any pending response
// and leaves no line loaded.
// ----------------------------------------------------------------------------
module line_pixel_generator #(
   parameter int COORD_BITS  = lpg_pkg::COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = lpg_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_pixel_x,
   output logic signed [COORD_BITS-1:0] rsp_pixel_y,
   output logic                         rsp_last
);
   import lpg_pkg::*;

   localparam int ITEM_BITS = lpg_item_bits(COORD_BITS);

   // Classified transactions leaving the front end.
   logic                 front_valid;
   logic                 front_ready;
   logic [ITEM_BITS-1:0] front_data;

   // Head of the queue as seen by the engine.
   logic                 queue_valid;
   logic [ITEM_BITS-1:0] queue_data;
   logic                 queue_pop;

   lpg_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .item_valid  (front_valid),
      .item_data   (front_data),
      .item_ready  (front_ready)
   );

   // The queue lets the front keep accepting while the engine waits on a
   // stalled response, and lets loads and idle steps drain independently.
   lpg_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_data  (queue_data),
      .out_pop   (queue_pop)
   );

   // The engine holds the line state and the response register.
   lpg_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (queue_valid),
      .item_data   (queue_data),
      .item_pop    (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_pixel_x (rsp_pixel_x),
      .rsp_pixel_y (rsp_pixel_y),
      .rsp_last    (rsp_last)
   );

endmodule

FILE: sv/lpg_checker.sv
// ----------------------------------------------------------------------------
// Line pixel generator checker
// Port-level assertions on the line pixel generator, attached by bind.
// ----------------------------------------------------------------------------
`include "line_pixel_generator_macros.svh"

module lpg_checker #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [COORD_BITS-1:0] rsp_pixel_x,
   input logic signed [COORD_BITS-1:0] rsp_pixel_y,
   input logic                         rsp_last
);
   import lpg_pkg::*;

   logic                    rsp_waiting;
   logic [2*COORD_BITS:0]   rsp_word;

   // A response offered under stall, outside reset.
   assign rsp_waiting = rsp_valid && rsp_stall && !reset;
   assign rsp_word    = {rsp_pixel_x, rsp_pixel_y, rsp_last};

   // A stalled response stays offered.
   `LPG_ASSERT_IMPLY(a_rsp_hold, clock, reset, $past(rsp_waiting), rsp_valid)

   // A stalled response keeps its pixel and flag.
   `LPG_ASSERT_IMPLY(a_rsp_stable, clock, reset, $past(rsp_waiting), $stable(rsp_word))

   // Reset leaves no response pending and the request side open.
   `LPG_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset), !rsp_valid && !req_stall)

   // A free response side outside reset drains the queue below full by the cycle after.
   `LPG_ASSERT_IMPLY(a_no_backlog, clock, reset, $past(!rsp_stall && !reset), !req_stall)

endmodule

bind line_pixel_generator lpg_checker #(.COORD_BITS(COORD_BITS)) u_lpg_checker (.*);
